/* hdl/lsc_pkg.sv */
// ----------------------------------------------------------------------------
// lsc_pkg
// Shared types and constants for the layer stack combiner.
// ----------------------------------------------------------------------------
package lsc_pkg;

   localparam int FRAC_BITS_DEF = 16;

   typedef enum logic [1:0] {
      KIND_START = 2'd0,
      KIND_FRONT = 2'd1,
      KIND_BACK  = 2'd2
   } kind_type;

   // Product schedule of the shared multiplier
   typedef enum logic [2:0] {
      MS_DEN  = 3'd0,
      MS_TF   = 3'd1,
      MS_TB   = 3'd2,
      MS_TFTB = 3'd3,
      MS_RF   = 3'd4,
      MS_TBTF = 3'd5,
      MS_RB   = 3'd6
   } mul_step_type;

   localparam logic [1:0] DIV_LAST = 2'd3;

   typedef struct packed {
      logic         accept;
      logic         mul_en;
      mul_step_type mul_step;
      logic         div_load;
      logic         div_step;
      logic         div_store;
      logic [1:0]   div_sel;
      logic         update;
      logic         publish;
   } cmd_type;

   typedef struct packed {
      logic d_zero;
   } status_type;

endpackage

/* hdl/lsc_ctrl.sv */
// ----------------------------------------------------------------------------
// lsc_ctrl
// Sequencer: products on the shared multiplier, four divisions, update and
// result hand-off.
// ----------------------------------------------------------------------------
module lsc_ctrl #(
   parameter int FRAC_BITS = lsc_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_kind,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output lsc_pkg::cmd_type   cmd,
   input  lsc_pkg::status_type status
);

   localparam int STEPS = FRAC_BITS + 2;
   localparam int CW    = $clog2(STEPS + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_MUL, S_DIV_LOAD, S_DIV_RUN, S_DIV_STORE, S_UPDATE, S_PUBLISH
   } state_type;

   state_type             state_ff;
   lsc_pkg::mul_step_type step_ff;
   logic [CW-1:0]         cnt_ff;
   logic [1:0]            sel_ff;
   logic                  rsp_valid_ff;
   logic                  accept;
   logic                  out_free;
   logic                  combine;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign combine   = (lsc_pkg::kind_type'(req_kind) == lsc_pkg::KIND_FRONT) ||
                      (lsc_pkg::kind_type'(req_kind) == lsc_pkg::KIND_BACK);

   always_comb begin
      cmd           = '0;
      cmd.accept    = accept;
      cmd.mul_en    = (state_ff == S_MUL);
      cmd.mul_step  = step_ff;
      cmd.div_load  = (state_ff == S_DIV_LOAD);
      cmd.div_step  = (state_ff == S_DIV_RUN);
      cmd.div_store = (state_ff == S_DIV_STORE);
      cmd.div_sel   = sel_ff;
      cmd.update    = (state_ff == S_UPDATE);
      cmd.publish   = (state_ff == S_PUBLISH) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= lsc_pkg::MS_DEN;
         cnt_ff       <= '0;
         sel_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.publish)
            rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)
            rsp_valid_ff <= 1'b0;

         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  step_ff  <= lsc_pkg::MS_DEN;
                  state_ff <= combine ? S_MUL : S_UPDATE;
               end
            end
            S_MUL: begin
               sel_ff <= '0;
               // zero divisor: skip straight to the saturated update
               if (step_ff == lsc_pkg::MS_TF && status.d_zero)
                  state_ff <= S_UPDATE;
               else if (step_ff == lsc_pkg::MS_RB)
                  state_ff <= S_DIV_LOAD;
               else
                  step_ff <= lsc_pkg::mul_step_type'(step_ff + 3'd1);
            end
            S_DIV_LOAD: begin
               cnt_ff   <= '0;
               state_ff <= S_DIV_RUN;
            end
            S_DIV_RUN: begin
               cnt_ff <= cnt_ff + CW'(1);
               if (cnt_ff == CW'(STEPS - 1))
                  state_ff <= S_DIV_STORE;
            end
            S_DIV_STORE: begin
               if (sel_ff == lsc_pkg::DIV_LAST) begin
                  state_ff <= S_UPDATE;
               end else begin
                  sel_ff   <= sel_ff + 2'd1;
                  state_ff <= S_DIV_LOAD;
               end
            end
            S_UPDATE:  state_ff <= S_PUBLISH;
            S_PUBLISH: begin
               if (out_free)
                  state_ff <= S_IDLE;
            end
            default:   state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

/* hdl/lsc_datapath.sv */
// ----------------------------------------------------------------------------
// lsc_datapath
// Stack registers, shared rounding multiplier, restoring divider and the
// saturating update.
// ----------------------------------------------------------------------------
module lsc_datapath #(
   parameter int FRAC_BITS = lsc_pkg::FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lsc_pkg::cmd_type     cmd,
   output lsc_pkg::status_type  status,
   input  logic [1:0]           req_kind,
   input  logic [FRAC_BITS:0]   req_layer_front_transmit,
   input  logic [FRAC_BITS:0]   req_layer_front_reflect,
   input  logic [FRAC_BITS:0]   req_layer_back_transmit,
   input  logic [FRAC_BITS:0]   req_layer_back_reflect,
   output logic [FRAC_BITS:0]   rsp_front_transmit,
   output logic [FRAC_BITS:0]   rsp_front_reflect,
   output logic [FRAC_BITS:0]   rsp_back_transmit,
   output logic [FRAC_BITS:0]   rsp_back_reflect,
   output logic                 rsp_saturate_fault
);

   localparam int F  = FRAC_BITS;
   localparam int W  = F + 1;
   localparam int QW = F + 2;
   localparam int NW = 2 * F + 1;
   localparam logic [W-1:0] ONE = {1'b1, {F{1'b0}}};

   // layer (clipped) and stack
   logic [W-1:0] ltf_ff, lrf_ff, ltb_ff, lrb_ff;
   logic [W-1:0] stf_ff, srf_ff, stb_ff, srb_ff;
   lsc_pkg::kind_type kind_ff;
   logic         fault_ff;

   // products and divisor
   logic [W-1:0] d_ff, ptf_ff, ptb_ff, pq_ff, prf_ff, pr_ff, prb_ff;

   // divider
   logic [QW-1:0] rem_ff, low_ff;
   logic          ovf_ff;
   logic [QW-1:0] quo_ff [4];
   logic [3:0]    qovf_ff;

   logic [W-1:0] tf1, rf1, tb1, rb1, tf2, rf2, tb2, rb2;
   logic [W-1:0] ma, mb, mres;
   logic [2*W-1:0] prod, rnd;
   logic [W-1:0] dnum;
   logic [NW-1:0] num;
   logic [QW-1:0] trial;
   logic          ge;
   logic [W-1:0] ntf, ntb, nrf, nrb;
   logic          f_tf, f_tb, f_rf, f_rb;
   logic [QW:0]  sum_rf, sum_rb;

   assign status.d_zero = (d_ff == '0);

   always_comb begin
      if (kind_ff == lsc_pkg::KIND_FRONT) begin
         tf1 = ltf_ff; rf1 = lrf_ff; tb1 = ltb_ff; rb1 = lrb_ff;
         tf2 = stf_ff; rf2 = srf_ff; tb2 = stb_ff; rb2 = srb_ff;
      end else begin
         tf1 = stf_ff; rf1 = srf_ff; tb1 = stb_ff; rb1 = srb_ff;
         tf2 = ltf_ff; rf2 = lrf_ff; tb2 = ltb_ff; rb2 = lrb_ff;
      end
   end

   always_comb begin
      unique case (cmd.mul_step)
         lsc_pkg::MS_DEN:  begin ma = rb1;   mb = rf2; end
         lsc_pkg::MS_TF:   begin ma = tf1;   mb = tf2; end
         lsc_pkg::MS_TB:   begin ma = tb1;   mb = tb2; end
         lsc_pkg::MS_TFTB: begin ma = tf1;   mb = tb1; end
         lsc_pkg::MS_RF:   begin ma = pq_ff; mb = rf2; end
         lsc_pkg::MS_TBTF: begin ma = tb2;   mb = tf2; end
         lsc_pkg::MS_RB:   begin ma = pr_ff; mb = rb1; end
         default:          begin ma = '0;    mb = '0;  end
      endcase
   end

   // round half up
   assign prod = ma * mb;
   assign rnd  = prod + ((2*W)'(1) << (F - 1));
   assign mres = rnd[F+W-1:F];

   always_comb begin
      unique case (cmd.div_sel)
         2'd0:    dnum = ptf_ff;
         2'd1:    dnum = ptb_ff;
         2'd2:    dnum = prf_ff;
         default: dnum = prb_ff;
      endcase
   end

   assign num   = {dnum, {F{1'b0}}} + NW'(d_ff >> 1);
   assign trial = {rem_ff[QW-2:0], low_ff[QW-1]};
   assign ge    = (trial >= QW'(d_ff));

   always_comb begin
      f_tf = qovf_ff[0] || (quo_ff[0] > QW'(ONE));
      f_tb = qovf_ff[1] || (quo_ff[1] > QW'(ONE));
      sum_rf = (QW+1)'(rf1) + (QW+1)'(quo_ff[2]);
      sum_rb = (QW+1)'(rb2) + (QW+1)'(quo_ff[3]);
      f_rf = qovf_ff[2] || (sum_rf > (QW+1)'(ONE));
      f_rb = qovf_ff[3] || (sum_rb > (QW+1)'(ONE));
      ntf  = f_tf ? ONE : quo_ff[0][W-1:0];
      ntb  = f_tb ? ONE : quo_ff[1][W-1:0];
      nrf  = f_rf ? ONE : sum_rf[W-1:0];
      nrb  = f_rb ? ONE : sum_rb[W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stf_ff   <= '0;
         srf_ff   <= '0;
         stb_ff   <= '0;
         srb_ff   <= '0;
         fault_ff <= 1'b0;
         kind_ff  <= lsc_pkg::KIND_START;
      end else begin
         if (cmd.accept) begin
            kind_ff  <= lsc_pkg::kind_type'(req_kind);
            ltf_ff   <= (req_layer_front_transmit > ONE) ? ONE : req_layer_front_transmit;
            lrf_ff   <= (req_layer_front_reflect  > ONE) ? ONE : req_layer_front_reflect;
            ltb_ff   <= (req_layer_back_transmit  > ONE) ? ONE : req_layer_back_transmit;
            lrb_ff   <= (req_layer_back_reflect   > ONE) ? ONE : req_layer_back_reflect;
            fault_ff <= (req_layer_front_transmit > ONE) || (req_layer_front_reflect > ONE) ||
                        (req_layer_back_transmit  > ONE) || (req_layer_back_reflect  > ONE);
         end
         if (cmd.update) begin
            unique case (kind_ff)
               lsc_pkg::KIND_START: begin
                  stf_ff <= ltf_ff; srf_ff <= lrf_ff;
                  stb_ff <= ltb_ff; srb_ff <= lrb_ff;
               end
               lsc_pkg::KIND_FRONT, lsc_pkg::KIND_BACK: begin
                  if (status.d_zero) begin
                     stf_ff <= ONE; srf_ff <= ONE; stb_ff <= ONE; srb_ff <= ONE;
                     fault_ff <= 1'b1;
                  end else begin
                     stf_ff <= ntf; srf_ff <= nrf; stb_ff <= ntb; srb_ff <= nrb;
                     fault_ff <= fault_ff || f_tf || f_tb || f_rf || f_rb;
                  end
               end
               // unused kind: hold the stack, report no fault
               default: fault_ff <= 1'b0;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         unique case (cmd.mul_step)
            lsc_pkg::MS_DEN:  d_ff   <= ONE - mres;
            lsc_pkg::MS_TF:   ptf_ff <= mres;
            lsc_pkg::MS_TB:   ptb_ff <= mres;
            lsc_pkg::MS_TFTB: pq_ff  <= mres;
            lsc_pkg::MS_RF:   prf_ff <= mres;
            lsc_pkg::MS_TBTF: pr_ff  <= mres;
            lsc_pkg::MS_RB:   prb_ff <= mres;
            default:          pr_ff  <= pr_ff;
         endcase
      end
      if (cmd.div_load) begin
         rem_ff <= QW'(num[NW-1:QW]);
         low_ff <= num[QW-1:0];
         // quotient would not fit in QW bits
         ovf_ff <= (QW'(num[NW-1:QW]) >= QW'(d_ff));
      end
      if (cmd.div_step) begin
         rem_ff <= ge ? (trial - QW'(d_ff)) : trial;
         low_ff <= {low_ff[QW-2:0], ge};
      end
      if (cmd.div_store) begin
         quo_ff[cmd.div_sel]  <= low_ff;
         qovf_ff[cmd.div_sel] <= ovf_ff;
      end
      if (cmd.publish) begin
         rsp_front_transmit <= stf_ff;
         rsp_front_reflect  <= srf_ff;
         rsp_back_transmit  <= stb_ff;
         rsp_back_reflect   <= srb_ff;
         rsp_saturate_fault <= fault_ff;
      end
   end

endmodule

/* hdl/layer_stack_combiner.sv */
// ----------------------------------------------------------------------------
// layer_stack_combiner
// Equivalent optical stack built layer by layer with interreflection.
// ----------------------------------------------------------------------------
// Start or unused kind: the request goes straight to the update; front/back
// first use the shared multiplier (seven products) and the one-bit-per-cycle
// divider run four times, or go to a saturated update on a zero divisor.
// Throughput: one request at a time; a new request is taken while the result
// waits. Reset clears the stack to zero and drops any pending result.
module layer_stack_combiner #(
   parameter int FRAC_BITS = lsc_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_kind,
   input  logic [FRAC_BITS:0] req_layer_front_transmit,
   input  logic [FRAC_BITS:0] req_layer_front_reflect,
   input  logic [FRAC_BITS:0] req_layer_back_transmit,
   input  logic [FRAC_BITS:0] req_layer_back_reflect,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [FRAC_BITS:0] rsp_front_transmit,
   output logic [FRAC_BITS:0] rsp_front_reflect,
   output logic [FRAC_BITS:0] rsp_back_transmit,
   output logic [FRAC_BITS:0] rsp_back_reflect,
   output logic               rsp_saturate_fault
);

   localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

   lsc_pkg::cmd_type    cmd;
   lsc_pkg::status_type status;

   lsc_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_kind  (req_kind),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   lsc_datapath #(.FRAC_BITS(FRAC_BITS)) u_datapath (
      .clock                    (clock),
      .reset                    (reset),
      .cmd                      (cmd),
      .status                   (status),
      .req_kind                 (req_kind),
      .req_layer_front_transmit (req_layer_front_transmit),
      .req_layer_front_reflect  (req_layer_front_reflect),
      .req_layer_back_transmit  (req_layer_back_transmit),
      .req_layer_back_reflect   (req_layer_back_reflect),
      .rsp_front_transmit       (rsp_front_transmit),
      .rsp_front_reflect        (rsp_front_reflect),
      .rsp_back_transmit        (rsp_back_transmit),
      .rsp_back_reflect         (rsp_back_reflect),
      .rsp_saturate_fault       (rsp_saturate_fault)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("block not busy after accepting a request");

   a_result_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without a request in progress");

   a_result_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_front_transmit <= ONE) && (rsp_front_reflect <= ONE) &&
                    (rsp_back_transmit <= ONE) && (rsp_back_reflect <= ONE))
      else $error("result value above 1.0");

endmodule
